### hw/rtl/sdpc_pkg.sv
`default_nettype none
package sdpc_pkg;

    localparam int ANGLE_ITERATIONS = 16;
    localparam int CORDIC_STEPS = (ANGLE_ITERATIONS > 24) ? 24 : ANGLE_ITERATIONS;
    localparam int CORDIC_LAT = CORDIC_STEPS + 2;
    localparam int DIV_STAGES = 25;
    localparam int SQRT_STAGES = 13;
    localparam int BACK_LAT = DIV_STAGES + SQRT_STAGES;
    localparam int FRONT_LAT = 3;
    localparam int PIPE_LAT = FRONT_LAT + BACK_LAT;
    localparam int HEAD_PAD = BACK_LAT - CORDIC_LAT;
    localparam int CW = 27;
    localparam int AW = 33;

    typedef enum logic [1:0] {
        TURN_NONE  = 2'd0,
        TURN_LEFT  = 2'd1,
        TURN_RIGHT = 2'd2
    } cam_t;

    typedef enum logic [1:0] {
        REG_LEFT_DZ  = 2'd0,
        REG_RIGHT_DZ = 2'd1,
        REG_CAM_INV  = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [30:0]        xsq;
        logic [30:0]        ysq;
        logic [31:0]        s;
        logic [12:0]        xmag;
        logic [12:0]        ymag;
        logic               big;
        logic               dead;
        cam_t               cam;
    } front_t;

    function automatic logic [29:0] atan_entry(input logic [4:0] idx);
        logic [29:0] v;
        case (idx)
            5'd0:  v = 30'h20000000;
            5'd1:  v = 30'h12E4051E;
            5'd2:  v = 30'h09FB385B;
            5'd3:  v = 30'h051111D4;
            5'd4:  v = 30'h028B0D43;
            5'd5:  v = 30'h0145D7E1;
            5'd6:  v = 30'h00A2F61E;
            5'd7:  v = 30'h00517C55;
            5'd8:  v = 30'h0028BE53;
            5'd9:  v = 30'h00145F2F;
            5'd10: v = 30'h000A2F98;
            5'd11: v = 30'h000517CC;
            5'd12: v = 30'h00028BE6;
            5'd13: v = 30'h000145F3;
            5'd14: v = 30'h0000A2F9;
            5'd15: v = 30'h0000517C;
            5'd16: v = 30'h000028BE;
            5'd17: v = 30'h0000145F;
            5'd18: v = 30'h00000A2F;
            5'd19: v = 30'h00000517;
            5'd20: v = 30'h0000028B;
            5'd21: v = 30'h00000145;
            5'd22: v = 30'h000000A2;
            5'd23: v = 30'h00000051;
            default: v = 30'h0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

### hw/rtl/sdpc_front.sv
`default_nettype none
module sdpc_front (
    input  wire logic                aclk,
    input  wire logic                ce,
    input  wire logic signed [15:0]  left_x,
    input  wire logic signed [15:0]  left_y,
    input  wire logic signed [15:0]  right_x,
    input  wire logic [14:0]         left_dz,
    input  wire logic [14:0]         right_dz,
    input  wire logic                cam_inv,
    output sdpc_pkg::front_t         fr
);
    import sdpc_pkg::*;

    logic [16:0]        ax, ay, ax1_reg, ay1_reg, ax2_reg, ay2_reg;
    logic signed [16:0] rx_ext, rd_ext;
    logic               rx_gt, rx_lt, dead_next;
    cam_t               cam_next;
    logic signed [15:0] x1_reg, y1_reg, x2_reg, y2_reg;
    logic               dead1_reg, dead2_reg;
    cam_t               cam1_reg, cam2_reg;
    logic signed [31:0] xsq_full, ysq_full;
    logic [30:0]        xsq2_reg, ysq2_reg;
    front_t             fr_reg, fr_next;

    assign ax = left_x[15] ? (17'd0 - {left_x[15], left_x}) : {1'b0, left_x};
    assign ay = left_y[15] ? (17'd0 - {left_y[15], left_y}) : {1'b0, left_y};
    assign dead_next = !((ax > {2'b0, left_dz}) || (ay > {2'b0, left_dz}));
    assign rx_ext = {right_x[15], right_x};
    assign rd_ext = $signed({2'b0, right_dz});
    assign rx_gt = rx_ext > rd_ext;
    assign rx_lt = rx_ext < -rd_ext;

    always_comb begin
        if (rx_gt) begin
            cam_next = cam_inv ? TURN_LEFT : TURN_RIGHT;
        end else if (rx_lt) begin
            cam_next = cam_inv ? TURN_RIGHT : TURN_LEFT;
        end else begin
            cam_next = TURN_NONE;
        end
    end

    assign xsq_full = x1_reg * x1_reg;
    assign ysq_full = y1_reg * y1_reg;

    always_comb begin
        fr_next.x    = x2_reg;
        fr_next.y    = y2_reg;
        fr_next.xsq  = xsq2_reg;
        fr_next.ysq  = ysq2_reg;
        fr_next.s    = {1'b0, xsq2_reg} + {1'b0, ysq2_reg};
        fr_next.big  = fr_next.s > 32'h4000_0000;
        fr_next.xmag = ax2_reg[15:3];
        fr_next.ymag = ay2_reg[15:3];
        fr_next.dead = dead2_reg;
        fr_next.cam  = cam2_reg;
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            x1_reg    <= left_x;
            y1_reg    <= left_y;
            ax1_reg   <= ax;
            ay1_reg   <= ay;
            dead1_reg <= dead_next;
            cam1_reg  <= cam_next;
            x2_reg    <= x1_reg;
            y2_reg    <= y1_reg;
            ax2_reg   <= ax1_reg;
            ay2_reg   <= ay1_reg;
            dead2_reg <= dead1_reg;
            cam2_reg  <= cam1_reg;
            xsq2_reg  <= xsq_full[30:0];
            ysq2_reg  <= ysq_full[30:0];
            fr_reg    <= fr_next;
        end
    end

    assign fr = fr_reg;

endmodule
`default_nettype wire

### hw/rtl/sdpc_cordic.sv
`default_nettype none
module sdpc_cordic (
    input  wire logic               aclk,
    input  wire logic               ce,
    input  wire logic signed [15:0] x,
    input  wire logic signed [15:0] y,
    output logic [15:0]             heading
);
    import sdpc_pkg::*;

    typedef struct packed {
        logic xz;
        logic yz;
        logic xpos;
        logic ypos;
    } cflag_t;

    logic signed [CW-1:0] re_reg  [CORDIC_STEPS+1];
    logic signed [CW-1:0] im_reg  [CORDIC_STEPS+1];
    logic signed [AW-1:0] acc_reg [CORDIC_STEPS+1];
    cflag_t               fl_reg  [CORDIC_STEPS+1];
    logic signed [CW-1:0] re0, im0, re_pre, im_pre;
    logic signed [AW-1:0] acc_pre, ang, ang_adj;
    cflag_t               fl_pre, fl_last;
    logic [15:0]          t_lo, heading_reg, heading_next;

    assign re0 = {{3{y[15]}}, y, 8'b0};
    assign im0 = {{3{x[15]}}, x, 8'b0};

    always_comb begin
        re_pre  = re0;
        im_pre  = im0;
        acc_pre = '0;
        if (re0 < 0) begin
            if (im0 >= 0) begin
                re_pre  = im0;
                im_pre  = -re0;
                acc_pre = AW'(33'sh0_4000_0000);
            end else begin
                re_pre  = -im0;
                im_pre  = re0;
                acc_pre = -AW'(33'sh0_4000_0000);
            end
        end
        fl_pre.xz   = (x == 16'sd0);
        fl_pre.yz   = (y == 16'sd0);
        fl_pre.xpos = (x > 16'sd0);
        fl_pre.ypos = (y > 16'sd0);
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            re_reg[0]  <= re_pre;
            im_reg[0]  <= im_pre;
            acc_reg[0] <= acc_pre;
            fl_reg[0]  <= fl_pre;
        end
    end

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
        logic signed [CW-1:0] dre, dim;
        logic signed [AW-1:0] tab;
        assign dre = im_reg[k] >>> k;
        assign dim = re_reg[k] >>> k;
        assign tab = $signed({3'b0, atan_entry(5'(k))});
        always_ff @(posedge aclk) begin
            if (ce) begin
                if (!im_reg[k][CW-1]) begin
                    re_reg[k+1]  <= re_reg[k] + dre;
                    im_reg[k+1]  <= im_reg[k] - dim;
                    acc_reg[k+1] <= acc_reg[k] + tab;
                end else begin
                    re_reg[k+1]  <= re_reg[k] - dre;
                    im_reg[k+1]  <= im_reg[k] + dim;
                    acc_reg[k+1] <= acc_reg[k] - tab;
                end
                fl_reg[k+1] <= fl_reg[k];
            end
        end
    end

    assign fl_last = fl_reg[CORDIC_STEPS];

    always_comb begin
        if (fl_last.xz) begin
            ang = fl_last.ypos ? '0 : AW'(33'sh0_8000_0000);
        end else if (fl_last.yz) begin
            ang = fl_last.xpos ? AW'(33'sh0_4000_0000) : -AW'(33'sh0_4000_0000);
        end else begin
            ang = acc_reg[CORDIC_STEPS];
        end
        // truncate toward zero on the divide by 2^16
        ang_adj = ang + (ang[AW-1] ? AW'(65535) : AW'(0));
        t_lo = ang_adj[31:16];
        heading_next = 16'h0 - t_lo - 16'h8000;
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            heading_reg <= heading_next;
        end
    end

    assign heading = heading_reg;

endmodule
`default_nettype wire

### hw/rtl/sdpc_div.sv
`default_nettype none
module sdpc_div (
    input  wire logic        aclk,
    input  wire logic        ce,
    input  wire logic [30:0] num,
    input  wire logic [31:0] den,
    output logic [24:0]      quo
);
    import sdpc_pkg::*;

    logic [32:0] rem_reg [DIV_STAGES];
    logic [31:0] den_reg [DIV_STAGES];
    logic [24:0] quo_reg [DIV_STAGES];

    // quotient of (num << 24) / den, one bit per stage, MSB first
    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        logic [32:0] rem_in;
        logic [31:0] den_in;
        logic [24:0] quo_in;
        logic        take;
        if (k == 0) begin : g_first
            assign rem_in = {2'b0, num};
            assign den_in = den;
            assign quo_in = '0;
        end else begin : g_next
            assign rem_in = {rem_reg[k-1][31:0], 1'b0};
            assign den_in = den_reg[k-1];
            assign quo_in = quo_reg[k-1];
        end
        assign take = rem_in >= {1'b0, den_in};
        always_ff @(posedge aclk) begin
            if (ce) begin
                rem_reg[k] <= take ? (rem_in - {1'b0, den_in}) : rem_in;
                den_reg[k] <= den_in;
                quo_reg[k] <= quo_in | (25'(take) << (DIV_STAGES - 1 - k));
            end
        end
    end

    assign quo = quo_reg[DIV_STAGES-1];

endmodule
`default_nettype wire

### hw/rtl/sdpc_isqrt.sv
`default_nettype none
module sdpc_isqrt (
    input  wire logic        aclk,
    input  wire logic        ce,
    input  wire logic [24:0] rad,
    output logic [12:0]      root
);
    import sdpc_pkg::*;

    logic [24:0] rem_reg  [SQRT_STAGES];
    logic [12:0] root_reg [SQRT_STAGES];

    for (genvar j = 0; j < SQRT_STAGES; j++) begin : g_stage
        localparam int B = SQRT_STAGES - 1 - j;
        logic [24:0] rem_in;
        logic [12:0] root_in;
        logic [26:0] trial;
        logic        take;
        if (j == 0) begin : g_first
            assign rem_in  = rad;
            assign root_in = '0;
        end else begin : g_next
            assign rem_in  = rem_reg[j-1];
            assign root_in = root_reg[j-1];
        end
        assign trial = ({14'b0, root_in} << (B + 1)) + (27'd1 << (2 * B));
        assign take  = {2'b0, rem_in} >= trial;
        always_ff @(posedge aclk) begin
            if (ce) begin
                rem_reg[j]  <= take ? 25'({2'b0, rem_in} - trial) : rem_in;
                root_reg[j] <= root_in | (13'(take) << B);
            end
        end
    end

    assign root = root_reg[SQRT_STAGES-1];

endmodule
`default_nettype wire

### hw/rtl/stick_deadzone_polar_convert.sv
`default_nettype none
// channel  | dir | tdata fields, low bit first
// s_       | in  | left_x[15:0] left_y[31:16] right_x[47:32]
// m_       | out | magnitude[12:0] heading[28:13] dir_x[42:29] dir_z[56:43]
//          |     | camera_turn[58:57], zero pad to 64
// cfg_     | in  | 0 left_deadzone, 1 right_deadzone, 2 camera_invert
//
// One sample per cycle unless the output stalls. Samples pass 3 front, 25 divider
// and 13 square-root stages and one output register; divider and root set the depth.
// Reset clears valid bits and restores register defaults.
// A stalled output freezes the whole pipeline; s_tready = !m_tvalid | m_tready.
module stick_deadzone_polar_convert (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // left_x, left_y, right_x
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // magnitude, heading, dir_x, dir_z, camera_turn
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [14:0] cfg_wdata
);
    import sdpc_pkg::*;

    typedef struct packed {
        logic        dead;
        logic        big;
        logic        xneg;
        logic        yneg;
        logic [12:0] xmag;
        logic [12:0] ymag;
        cam_t        cam;
    } side_t;

    logic [14:0] left_dz_reg, right_dz_reg;
    logic        cam_inv_reg;
    logic        ce;
    logic        vld_reg [PIPE_LAT];
    logic        m_tvalid_reg;
    logic [63:0] m_tdata_reg, m_tdata_next;
    front_t      fr;
    side_t       side_in;
    side_t       side_reg [BACK_LAT];
    logic [24:0] magrad_reg [DIV_STAGES];
    logic [15:0] head_reg [HEAD_PAD];
    logic [15:0] head_raw;
    logic [24:0] quo_x, quo_y;
    logic [12:0] root_x, root_y, root_m;
    logic [12:0] qx, qy, mag;
    logic signed [13:0] dx, dz;
    side_t       sd;

    assign ce       = !m_tvalid_reg || m_tready;
    assign s_tready = ce;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_dz_reg  <= 15'd7849;
            right_dz_reg <= 15'd8689;
            cam_inv_reg  <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_LEFT_DZ:  left_dz_reg  <= cfg_wdata;
                REG_RIGHT_DZ: right_dz_reg <= cfg_wdata;
                REG_CAM_INV:  cam_inv_reg  <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    sdpc_front u_front (
        .aclk     (aclk),
        .ce       (ce),
        .left_x   ($signed(s_tdata[15:0])),
        .left_y   ($signed(s_tdata[31:16])),
        .right_x  ($signed(s_tdata[47:32])),
        .left_dz  (left_dz_reg),
        .right_dz (right_dz_reg),
        .cam_inv  (cam_inv_reg),
        .fr       (fr)
    );

    sdpc_cordic u_cordic (
        .aclk    (aclk),
        .ce      (ce),
        .x       (fr.x),
        .y       (fr.y),
        .heading (head_raw)
    );

    sdpc_div u_div_x (.aclk(aclk), .ce(ce), .num(fr.xsq), .den(fr.s), .quo(quo_x));
    sdpc_div u_div_y (.aclk(aclk), .ce(ce), .num(fr.ysq), .den(fr.s), .quo(quo_y));

    sdpc_isqrt u_sqrt_x (.aclk(aclk), .ce(ce), .rad(quo_x), .root(root_x));
    sdpc_isqrt u_sqrt_y (.aclk(aclk), .ce(ce), .rad(quo_y), .root(root_y));
    sdpc_isqrt u_sqrt_m (.aclk(aclk), .ce(ce), .rad(magrad_reg[DIV_STAGES-1]),
                         .root(root_m));

    always_comb begin
        side_in.dead = fr.dead;
        side_in.big  = fr.big;
        side_in.xneg = fr.x[15];
        side_in.yneg = fr.y[15];
        side_in.xmag = fr.xmag;
        side_in.ymag = fr.ymag;
        side_in.cam  = fr.cam;
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            side_reg[0]   <= side_in;
            magrad_reg[0] <= fr.s[30:6];
            head_reg[0]   <= head_raw;
            for (int i = 1; i < BACK_LAT; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
            for (int i = 1; i < DIV_STAGES; i++) begin
                magrad_reg[i] <= magrad_reg[i-1];
            end
            for (int i = 1; i < HEAD_PAD; i++) begin
                head_reg[i] <= head_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < PIPE_LAT; i++) begin
                vld_reg[i] <= 1'b0;
            end
            m_tvalid_reg <= 1'b0;
        end else if (ce) begin
            vld_reg[0] <= s_tvalid;
            for (int i = 1; i < PIPE_LAT; i++) begin
                vld_reg[i] <= vld_reg[i-1];
            end
            m_tvalid_reg <= vld_reg[PIPE_LAT-1];
        end
    end

    assign sd = side_reg[BACK_LAT-1];

    always_comb begin
        qx  = sd.big ? root_x : sd.xmag;
        qy  = sd.big ? root_y : sd.ymag;
        mag = sd.big ? 13'd4096 : root_m;
        dx  = sd.xneg ? $signed(14'd0 - {1'b0, qx}) : $signed({1'b0, qx});
        dz  = sd.yneg ? $signed({1'b0, qy}) : $signed(14'd0 - {1'b0, qy});
        m_tdata_next = '0;
        m_tdata_next[58:57] = sd.cam;
        if (!sd.dead) begin
            m_tdata_next[12:0]  = mag;
            m_tdata_next[28:13] = head_reg[HEAD_PAD-1];
            m_tdata_next[42:29] = dx;
            m_tdata_next[56:43] = dz;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTHESIS
    a_mag_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[12:0] <= 13'd4096))
        else $error("magnitude above full scale");
    a_cam_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[58:57] != 2'd3))
        else $error("bad camera code");
    a_zero_mag_dir: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[12:0] == 13'd0) |->
        (m_tdata[42:29] == 14'd0 && m_tdata[56:43] == 14'd0))
        else $error("direction nonzero with zero magnitude");
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[63:59] == 5'd0))
        else $error("pad bits set");
`endif

endmodule
`default_nettype wire

### dv/stick_deadzone_polar_convert_tb.sv
`timescale 1ns / 100ps
`default_nettype none
module stick_deadzone_polar_convert_tb;
    import sdpc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [12:0] magnitude;
        logic [15:0] heading;
        logic [13:0] dir_x;
        logic [13:0] dir_z;
        logic [1:0]  camera_turn;
    } polar_t;

    typedef struct {
        logic signed [15:0] lx;
        logic signed [15:0] ly;
        logic signed [15:0] rx;
        bit                 known;
        polar_t             want;
    } sample_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [14:0] cfg_wdata = '0;

    logic [14:0] left_dz_q = 15'd7849;
    logic [14:0] right_dz_q = 15'd8689;
    logic        cam_inv_q = 1'b0;

    polar_t pending_polar[$];
    int     errors = 0;
    int     cycles = 0;
    int     hold_off = 0;
    bit     long_stall_done = 1'b0;
    bit     stall_random = 1'b0;

    stick_deadzone_polar_convert i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned root, bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    function automatic longint heading_acc(input longint x, input longint y);
        longint re, im, acc, t, dre, dim;
        acc = 0;
        if (x == 0) return (y > 0) ? 0 : (64'sd1 <<< 31);
        if (y == 0) return (x > 0) ? (64'sd1 <<< 30) : -(64'sd1 <<< 30);
        re = y * 256;
        im = x * 256;
        if (re < 0) begin
            if (im >= 0) begin
                t = im; im = -re; re = t; acc = 64'sd1 <<< 30;
            end else begin
                t = -im; im = re; re = t; acc = -(64'sd1 <<< 30);
            end
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dre = im >>> i;
            dim = re >>> i;
            if (im >= 0) begin
                re += dre; im -= dim; acc += longint'(atan_entry(5'(i)));
            end else begin
                re -= dre; im += dim; acc -= longint'(atan_entry(5'(i)));
            end
        end
        return acc;
    endfunction

    function automatic longint unit_component(input longint v, input longint unsigned s);
        longint unsigned a, q;
        a = (v < 0) ? -v : v;
        if (s <= (64'd1 << 30)) q = a >> 3;
        else q = int_sqrt(((a * a) << 24) / s);
        return (v < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic polar_t polar_of(input logic signed [15:0] lx,
                                        input logic signed [15:0] ly,
                                        input logic signed [15:0] rx);
        polar_t r;
        longint x, y, ax, ay, t, rxl, rdz;
        longint unsigned s;
        r = '0;
        x = lx; y = ly; rxl = rx; rdz = right_dz_q;
        ax = (x < 0) ? -x : x;
        ay = (y < 0) ? -y : y;
        if (ax > left_dz_q || ay > left_dz_q) begin
            s = x * x + y * y;
            t = heading_acc(x, y) / 65536;
            r.magnitude = (s > (64'd1 << 30)) ? 13'd4096 : 13'(int_sqrt(s >> 6));
            r.dir_x = 14'(unit_component(x, s));
            r.dir_z = 14'(-unit_component(y, s));
            r.heading = 16'(-t - 32768);
        end
        if (rxl > rdz) r.camera_turn = cam_inv_q ? TURN_LEFT : TURN_RIGHT;
        else if (rxl < -rdz) r.camera_turn = cam_inv_q ? TURN_RIGHT : TURN_LEFT;
        return r;
    endfunction

    function automatic polar_t unpack_result(input logic [63:0] d);
        polar_t r;
        r.magnitude = d[12:0];
        r.heading = d[28:13];
        r.dir_x = d[42:29];
        r.dir_z = d[56:43];
        r.camera_turn = d[58:57];
        return r;
    endfunction

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("stick_deadzone_polar_convert_tb: FAIL");
            $finish;
        end
    end

    // receiver; the first time random stalls start it holds off for a long stretch
    always @(posedge aclk) begin
        if (stall_random && !long_stall_done) begin
            m_tready <= 1'b0;
            hold_off <= 200;
            long_stall_done <= 1'b1;
        end else if (hold_off > 0) begin
            m_tready <= 1'b0;
            hold_off <= hold_off - 1;
        end else if (stall_random) begin
            m_tready <= (cycles % 13 < 9) ? ($urandom_range(0, 3) != 0) : 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        polar_t got, exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            got = unpack_result(m_tdata);
            if (pending_polar.size() == 0) begin
                $error("result transfer with nothing expected: %h", m_tdata);
                errors++;
            end else begin
                exp_r = pending_polar.pop_front();
                if (got.magnitude !== exp_r.magnitude) begin
                    $error("magnitude exp %0d got %0d", exp_r.magnitude, got.magnitude);
                    errors++;
                end
                if (got.heading !== exp_r.heading) begin
                    $error("heading exp %0d got %0d", exp_r.heading, got.heading);
                    errors++;
                end
                if (got.dir_x !== exp_r.dir_x) begin
                    $error("dir_x exp %0d got %0d", $signed(exp_r.dir_x), $signed(got.dir_x));
                    errors++;
                end
                if (got.dir_z !== exp_r.dir_z) begin
                    $error("dir_z exp %0d got %0d", $signed(exp_r.dir_z), $signed(got.dir_z));
                    errors++;
                end
                if (got.camera_turn !== exp_r.camera_turn) begin
                    $error("camera_turn exp %0d got %0d", exp_r.camera_turn, got.camera_turn);
                    errors++;
                end
            end
        end
    end

    task automatic send_sample(input logic signed [15:0] lx, input logic signed [15:0] ly,
                               input logic signed [15:0] rx, input bit known,
                               input polar_t want);
        polar_t p;
        p = polar_of(lx, ly, rx);
        if (known && p !== want) begin
            $error("predictor disagrees with table: exp %h pred %h", want, p);
            errors++;
        end
        s_tdata <= {rx, ly, lx};
        s_tvalid <= 1'b1;
        pending_polar.push_back(p);
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drop_valid();
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic drain();
        while (pending_polar.size() != 0) @(posedge aclk);
        repeat (PIPE_LAT + 8) @(posedge aclk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [14:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_LEFT_DZ:  left_dz_q = val;
            REG_RIGHT_DZ: right_dz_q = val;
            REG_CAM_INV:  cam_inv_q = val[0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    function automatic logic signed [15:0] pick_axis();
        case ($urandom_range(0, 5))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'($signed($urandom_range(0, 2000)) - 1000);
            3: return 16'($signed($urandom_range(0, 200)) - 100) + 16'sd8000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_phase(input int count);
        int burst;
        while (count > 0) begin
            burst = $urandom_range(1, 24);
            while (burst > 0 && count > 0) begin
                send_sample(pick_axis(), pick_axis(), pick_axis(), 1'b0, '0);
                burst--;
                count--;
            end
            if ($urandom_range(0, 2) != 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b0;
    endtask

    sample_row_t directed[] = '{
        '{16'sd0, 16'sd0, 16'sd0, 1'b1, polar_t'('0)},
        '{16'sd7849, -16'sd7849, 16'sd8689, 1'b1, polar_t'('0)},
        '{16'sd0, 16'sd0, 16'sd8690, 1'b1, '{13'd0, 16'd0, 14'd0, 14'd0, TURN_RIGHT}},
        '{16'sd0, 16'sd0, -16'sd8690, 1'b1, '{13'd0, 16'd0, 14'd0, 14'd0, TURN_LEFT}},
        '{16'sd0, 16'sd16384, 16'sd0, 1'b1,
          '{13'd2048, 16'd32768, 14'd0, -14'sd2048, TURN_NONE}},
        '{16'sd0, -16'sd16384, 16'sd0, 1'b1,
          '{13'd2048, 16'd0, 14'd0, 14'sd2048, TURN_NONE}},
        '{16'sd16384, 16'sd0, 16'sd0, 1'b1,
          '{13'd2048, 16'd16384, 14'sd2048, 14'd0, TURN_NONE}},
        '{-16'sd16384, 16'sd0, 16'sd0, 1'b1,
          '{13'd2048, 16'd49152, -14'sd2048, 14'd0, TURN_NONE}},
        '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b0, polar_t'('0)},
        '{16'sh8000, 16'sh8000, 16'sh8000, 1'b0, polar_t'('0)},
        '{16'sh8000, 16'sh7FFF, 16'sd0, 1'b0, polar_t'('0)},
        '{16'sh7FFF, 16'sh8000, 16'sd0, 1'b0, polar_t'('0)},
        '{16'sd7850, 16'sd0, 16'sd0, 1'b0, polar_t'('0)},
        '{16'sd0, -16'sd7850, 16'sd0, 1'b0, polar_t'('0)},
        '{16'sd20000, 16'sd25000, 16'sd0, 1'b0, polar_t'('0)},
        '{-16'sd20000, -16'sd25000, 16'sd0, 1'b0, polar_t'('0)},
        '{16'sd12000, -16'sd9000, 16'sd0, 1'b0, polar_t'('0)},
        '{-16'sd12000, 16'sd9000, 16'sd0, 1'b0, polar_t'('0)},
        '{16'sd1, 16'sd30000, 16'sh8000, 1'b0, polar_t'('0)},
        '{16'sd30000, -16'sd1, 16'sh7FFF, 1'b0, polar_t'('0)}
    };

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[i])
            send_sample(directed[i].lx, directed[i].ly, directed[i].rx,
                        directed[i].known, directed[i].want);
        drop_valid();
        drain();

        // long receiver hold-off so the pipeline fills and backpressures
        stall_random = 1'b1;
        random_phase(300);
        drain();

        write_reg(REG_LEFT_DZ, 15'd0);
        write_reg(REG_RIGHT_DZ, 15'd0);
        write_reg(REG_CAM_INV, 15'd1);
        random_phase(300);
        drain();

        write_reg(REG_LEFT_DZ, 15'h7FFF);
        write_reg(REG_RIGHT_DZ, 15'h7FFF);
        random_phase(250);
        drain();

        write_reg(REG_LEFT_DZ, 15'($urandom_range(0, 16000)));
        write_reg(REG_RIGHT_DZ, 15'($urandom_range(0, 16000)));
        write_reg(REG_CAM_INV, 15'd0);
        stall_random = 1'b0;
        random_phase(250);
        drain();

        write_reg(REG_LEFT_DZ, 15'd7849);
        write_reg(REG_RIGHT_DZ, 15'd8689);
        stall_random = 1'b1;
        random_phase(300);
        drain();

        if (errors == 0) begin
            $display("stick_deadzone_polar_convert_tb: PASS");
        end else begin
            $display("stick_deadzone_polar_convert_tb: FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire

### stick_deadzone_polar_convert.f
hw/rtl/sdpc_pkg.sv
hw/rtl/sdpc_front.sv
hw/rtl/sdpc_cordic.sv
hw/rtl/sdpc_div.sv
hw/rtl/sdpc_isqrt.sv
hw/rtl/stick_deadzone_polar_convert.sv
dv/stick_deadzone_polar_convert_tb.sv
